// ----- src/uvst_pkg.sv -----
// shared constants and codes for the unique value set table
`default_nettype none
package uvst_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 8;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2,
      OP_SPARE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_DELETED   = 3'd4,
      ST_ABSENT    = 3'd5,
      ST_EMPTY     = 3'd6,
      ST_FULL      = 3'd7
   } status_type;

endpackage
`default_nettype wire

// ----- src/unique_value_set_table.sv -----
// top level of the unique value set table
// Each request word asks to insert, search or delete one 32-bit value; every request gives
// exactly one response word with a status and the number of values held afterwards. Values
// sit in a 16-entry ram with registered read; valid marks sit in flip-flops cleared by reset.
// A request is taken in the idle state, which issues the first read; the scan state then
// compares one slot per cycle over the ram read port, and the commit state updates the store
// and loads the response register once it is free. A new request is taken once the previous
// one has committed, while its response may still wait for rsp_tready.
`default_nettype none
module unique_value_set_table
   import uvst_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // operation[1:0], value[33:2], zero pad
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [RSP_W-1:0] rsp_tdata    // status[2:0], entry_count[7:3]
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [CAPACITY-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   op_type                 op_ff, op_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic                   out_free;
   logic                   match;
   logic                   last;
   logic [IDX_W-1:0]       rd_addr;
   logic [VALUE_W-1:0]     rd_data;
   logic                   wr_en;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign match      = valid_ff[cmp_idx_ff] && (rd_data == value_ff);
   assign last       = (cmp_idx_ff == IDX_W'(CAPACITY - 1));
   assign rd_addr    = (state_ff == S_SCAN) ? cmp_idx_ff + IDX_W'(1) : '0;
   assign wr_en      = (state_ff == S_COMMIT) && out_free && (op_ff == OP_INSERT)
                       && !hit_ff && free_ff;

   uvst_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      rsp_count_in = rsp_count_ff;
      count_wide   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = op_type'(req_tdata[OP_W-1:0]);
               value_in   = req_tdata[OP_W +: VALUE_W];
               cmp_idx_in = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (match && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
            end
            if (!valid_ff[cmp_idx_ff] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
            cmp_idx_in = cmp_idx_ff + IDX_W'(1);
            if (last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               case (op_ff)
                  OP_INSERT: begin
                     if (hit_ff) begin
                        status_in = ST_DUPLICATE;
                     end else if (free_ff) begin
                        status_in             = ST_INSERTED;
                        valid_in[free_idx_ff] = 1'b1;
                        count_in              = count_ff + CNT_W'(1);
                     end else begin
                        status_in = ST_FULL;
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (hit_ff) begin
                        status_in            = ST_DELETED;
                        valid_in[hit_idx_ff] = 1'b0;
                        count_in             = count_ff - CNT_W'(1);
                     end else begin
                        status_in = ST_ABSENT;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (hit_ff) begin
                        status_in = ST_FOUND;
                     end else begin
                        status_in = ST_NOT_FOUND;
                     end
                  end
               endcase
               count_wide   = {{COUNT_W{1'b0}}, count_in};
               rsp_count_in = count_wide[COUNT_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      op_ff        <= op_in;
      value_ff     <= value_in;
      status_ff    <= status_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, status_ff};

endmodule
`default_nettype wire

// ----- src/uvst_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module uvst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ----- src/uvst_checker.sv -----
// port-level checks for the unique value set table and their binding
`default_nettype none
module uvst_checker
   import uvst_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic [REQ_W-1:0] req_tdata,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   logic req_word;
   assign req_word = req_tvalid && req_tready && (req_tdata[0] || !req_tdata[0]);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response word right after reset");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == ST_EMPTY) |-> (rsp_tdata[7:3] == '0))
      else $error("empty status with values held");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == ST_INSERTED || rsp_tdata[2:0] == ST_FOUND
      || rsp_tdata[2:0] == ST_DUPLICATE) |-> (CAPACITY > 31) || (rsp_tdata[7:3] != '0))
      else $error("value reported held in an empty store");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_word |=> !req_tready)
      else $error("request taken while another is in progress");

endmodule

bind unique_value_set_table uvst_checker u_uvst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking bench for the unique value set table: directed and random set operations
`timescale 1ns / 100ps
module testbench;
   import uvst_pkg::*;

   typedef struct {
      op_type      op;
      logic [31:0] value;
   } set_op_type;

   typedef struct {
      status_type         status;
      logic [COUNT_W-1:0] count;
   } set_answer_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;   // operation[1:0], value[33:2], zero pad
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // status[2:0], entry_count[7:3]

   set_op_type     pending_ops[$];
   set_answer_type expected_answers[$];

   logic [31:0] held_value[CAPACITY];
   logic        held_valid[CAPACITY];
   int          held_total = 0;

   int err_count    = 0;
   int ops_sent     = 0;
   int answers_seen = 0;
   int gap_left     = 0;
   int stall_left   = 0;
   int status_hits[8];

   unique_value_set_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      err_count++;
   endtask

   // every fourth block of 128 words runs with no idling at all
   function automatic int idle_gap(input int done);
      if ((done >> 7) % 4 == 0)
         return 0;
      return $urandom_range(0, 14);
   endfunction

   function automatic set_answer_type predict_answer(input set_op_type rq);
      set_answer_type ans;
      int             hit;
      int             spot;
      hit  = -1;
      spot = -1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (held_valid[i] && held_value[i] == rq.value && hit < 0)
            hit = i;
         if (!held_valid[i] && spot < 0)
            spot = i;
      end
      case (rq.op)
         OP_INSERT: begin
            if (hit >= 0)
               ans.status = ST_DUPLICATE;
            else if (spot >= 0) begin
               held_value[spot] = rq.value;
               held_valid[spot] = 1'b1;
               held_total++;
               ans.status = ST_INSERTED;
            end else
               ans.status = ST_FULL;
         end
         OP_DELETE: begin
            if (held_total == 0)
               ans.status = ST_EMPTY;
            else if (hit >= 0) begin
               held_valid[hit] = 1'b0;
               held_total--;
               ans.status = ST_DELETED;
            end else
               ans.status = ST_ABSENT;
         end
         default: begin
            if (held_total == 0)
               ans.status = ST_EMPTY;
            else if (hit >= 0)
               ans.status = ST_FOUND;
            else
               ans.status = ST_NOT_FOUND;
         end
      endcase
      ans.count = held_total[COUNT_W-1:0];
      return ans;
   endfunction

   task automatic add_op(input op_type op, input logic [31:0] value);
      set_op_type rq;
      rq.op    = op;
      rq.value = value;
      pending_ops.push_back(rq);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            expected_answers.push_back(predict_answer(pending_ops.pop_front()));
            ops_sent++;
            gap_left = idle_gap(ops_sent);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_W'({pending_ops[0].value, pending_ops[0].op});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor, stalls count down only while a word is offered
   always @(posedge clock) begin
      set_answer_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            status_hits[rsp_tdata[2:0]]++;
            if (expected_answers.size() == 0) begin
               report($sformatf("unexpected response word %h", rsp_tdata));
            end else begin
               want = expected_answers.pop_front();
               if (rsp_tdata[2:0] !== want.status)
                  report($sformatf("response %0d status %0d, want %0d",
                                   answers_seen, rsp_tdata[2:0], want.status));
               if (rsp_tdata[7:3] !== want.count)
                  report($sformatf("response %0d entry_count %0d, want %0d",
                                   answers_seen, rsp_tdata[7:3], want.count));
            end
            answers_seen++;
            stall_left = idle_gap(answers_seen);
         end else if (rsp_tvalid && stall_left > 0) begin
            stall_left--;
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   initial begin
      logic [31:0] pool[24];
      logic [31:0] v;
      bit          filling;
      int          roll;
      op_type      op;
      filling = 1'b1;
      for (int i = 0; i < CAPACITY; i++) begin
         held_value[i] = '0;
         held_valid[i] = 1'b0;
      end
      for (int i = 0; i < 8; i++)
         status_hits[i] = 0;

      // empty store
      add_op(OP_SEARCH, 32'h0000_0000);
      add_op(OP_DELETE, 32'h7fff_ffff);
      add_op(OP_SPARE,  32'h0000_0005);
      // extremes, duplicates, lookups
      add_op(OP_INSERT, 32'h8000_0000);
      add_op(OP_INSERT, 32'h8000_0000);
      add_op(OP_INSERT, 32'h7fff_ffff);
      add_op(OP_SEARCH, 32'h8000_0000);
      add_op(OP_SPARE,  32'h7fff_ffff);
      add_op(OP_SEARCH, 32'h0000_0000);
      add_op(OP_DELETE, 32'h7fff_ffff);
      add_op(OP_DELETE, 32'h7fff_ffff);
      // fill to capacity, then refuse a new value and a duplicate
      add_op(OP_INSERT, 32'h0000_0000);
      add_op(OP_INSERT, 32'hffff_ffff);
      for (int i = 1; i <= CAPACITY - 3; i++)
         add_op(OP_INSERT, 32'h1111_1111 * i);
      add_op(OP_INSERT, 32'h5555_aaaa);
      add_op(OP_INSERT, 32'h8000_0000);

      // runs that lean towards filling or draining a small pool of values
      for (int n = 0; n < 1900; n++) begin
         if (n % 400 == 0)
            for (int k = 0; k < 24; k++)
               pool[k] = (k < 4 && $urandom_range(0, 1)) ? {k[0], {31{k[1]}}} : $urandom;
         if (n % 40 == 0)
            filling = $urandom_range(0, 1);
         roll = $urandom_range(0, 99);
         if (roll < 5)
            op = OP_SPARE;
         else if (roll < 65)
            op = filling ? OP_INSERT : OP_DELETE;
         else if (roll < 85)
            op = OP_SEARCH;
         else
            op = filling ? OP_DELETE : OP_INSERT;
         v = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 23)];
         add_op(op, v);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() > 0 || req_tvalid)
         @(posedge clock);
      while (expected_answers.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("summary: %0d operations sent, %0d responses checked", ops_sent, answers_seen);
      $display("summary: ins %0d dup %0d found %0d miss %0d del %0d absent %0d empty %0d full %0d",
               status_hits[ST_INSERTED], status_hits[ST_DUPLICATE], status_hits[ST_FOUND],
               status_hits[ST_NOT_FOUND], status_hits[ST_DELETED], status_hits[ST_ABSENT],
               status_hits[ST_EMPTY], status_hits[ST_FULL]);
      if (err_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
